// ===== rtl/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

    // fraction bits of the slope result
    localparam int FRAC_BITS = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 2'd0,
        CFG_COL_COUNT = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_COL = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

endpackage

// ===== rtl/tli_ifs.sv =====
// ----------------------------------------------------------------------------
// tli_ifs
// Request, response and configuration channels of the interpolator.
// ----------------------------------------------------------------------------
interface tli_req_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [7:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] cell_value;
    logic [2:0]         x_col;
    logic [2:0]         y_col;
    logic signed [31:0] query_x;

    modport source (output valid, action, row_index, col_index, cell_value,
                    x_col, y_col, query_x, input ready);
    modport sink   (input valid, action, row_index, col_index, cell_value,
                    x_col, y_col, query_x, output ready);
endinterface

interface tli_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] y_value;
    logic signed [31:0] slope;
    logic [7:0]         interval_low;
    logic [1:0]         status;

    modport source (output valid, y_value, slope, interval_low, status, input ready);
    modport sink   (input valid, y_value, slope, interval_low, status, output ready);
endinterface

interface tli_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tli_pkg::CFG_IDX_W-1:0]   index;
    logic [tli_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tli_mem.sv =====
// ----------------------------------------------------------------------------
// tli_mem
// Single-port cell store with registered read data.
// ----------------------------------------------------------------------------
module tli_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_addr,
    input  logic [31:0]       i_wdata,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tli_div.sv =====
// ----------------------------------------------------------------------------
// tli_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tli_div #(
    parameter int QW = 33,
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [QW-1:0] o_quo
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= i_rem;
            r_quo  <= i_num;
            r_den  <= i_den;
            r_cnt  <= CNT_W'(QW);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            // shift in the next numerator bit, subtract when it fits
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo  <= {r_quo[QW-2:0], w_ge};
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear lookup over a table of signed Q16.16 cells.
// ----------------------------------------------------------------------------
// Channels: i_cfg writes row_count (index 0) and col_count (index 1); it is
// always ready. i_req carries either a cell write (action 0) or a query
// (action 1); o_rsp returns one result per query and nothing per write.
// A write goes straight to the cell store. A query binary-searches the x
// column, each probe of the cell store passing through S_PROBE and S_CMP,
// then reads the four interval cells x0, x1, y0 and y1. A query outside the
// interval is clamped to an end cell; an interior query adds a four-step
// partial-product multiply and a restoring divide for y and the slope.
// Errors and single-row queries skip the search.
// One request is worked on at a time; i_req is ready whenever the engine is
// idle, also while an earlier result still waits in the output register.
// If o_rsp stalls, a finished query holds until the output register frees.
// Reset sets row_count to 0 and col_count to 1; the cell store is not
// cleared, and cells must be written before a query reads them.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tli_cfg_if.sink i_cfg,
    tli_req_if.sink i_req,
    tli_rsp_if.source o_rsp
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_ROW0, S_ROW0W, S_PROBE, S_CMP, S_FETCH,
        S_EVAL, S_MUL, S_DSTART, S_DWAIT, S_RESP
    } t_state;

    t_state r_state;

    logic [8:0] r_row_count;
    logic [3:0] r_col_count;

    logic [2:0]         r_xc, r_yc;
    logic signed [31:0] r_qx;
    logic [RW-1:0]      r_lo, r_hi;
    logic [2:0]         r_cnt;
    logic signed [31:0] r_x0, r_x1, r_y0, r_y1;
    logic [32:0]        r_mag, r_dxx, r_dx;
    logic               r_neg;
    logic [65:0]        r_prod;

    logic               r_out_valid;
    logic signed [31:0] r_yv, r_sl;
    logic [7:0]         r_lo_out;
    logic [1:0]         r_st;

    logic signed [31:0] r_res_yv, r_res_sl;
    logic [7:0]         r_res_lo;
    logic [1:0]         r_res_st;
    logic               r_res_full;

    // ---------------- helpers ----------------
    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                              input logic [2:0] col);
        addr_of = AW'(row) * AW'(MAX_COLS) + AW'(col);
    endfunction

    logic [CNT_W-1:0] w_rows;
    logic             w_bad_col;
    logic [RW:0]      w_sum;
    logic [RW-1:0]    w_mid;
    logic [RW-1:0]    w_lo1;
    logic             w_more;

    always_comb begin
        if (32'(r_row_count) > MAX_ROWS) begin
            w_rows = CNT_W'(MAX_ROWS);
        end else begin
            w_rows = CNT_W'(r_row_count);
        end
    end

    assign w_bad_col = (32'(r_xc) >= 32'(r_col_count)) || (32'(r_xc) >= MAX_COLS) ||
                       (32'(r_yc) >= 32'(r_col_count)) || (32'(r_yc) >= MAX_COLS);
    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid  = w_sum[RW:1];
    assign w_lo1  = RW'({1'b0, r_lo} + 1'b1);
    assign w_more = ({1'b0, r_lo} + 1'b1) < {1'b0, r_hi};

    // ---------------- cell store ----------------
    logic          w_acc;
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [31:0]   w_rdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc = i_req.valid && i_req.ready;
    assign w_we  = w_acc && (i_req.action == tli_pkg::ACT_WRITE) &&
                   (32'(i_req.row_index) < MAX_ROWS) && (32'(i_req.col_index) < MAX_COLS);

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_addr = addr_of(RW'(i_req.row_index), i_req.col_index);
            S_ROW0:  w_addr = addr_of('0, r_yc);
            S_PROBE: w_addr = addr_of(w_mid, r_xc);
            S_FETCH: begin
                unique case (r_cnt[1:0])
                    2'd0:    w_addr = addr_of(r_lo, r_xc);
                    2'd1:    w_addr = addr_of(w_lo1, r_xc);
                    2'd2:    w_addr = addr_of(r_lo, r_yc);
                    default: w_addr = addr_of(w_lo1, r_yc);
                endcase
            end
            default: w_addr = '0;
        endcase
    end

    tli_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (i_req.cell_value),
        .o_rdata (w_rdata)
    );

    // ---------------- interval arithmetic ----------------
    logic signed [32:0] w_dy;
    logic [32:0]        w_dxx, w_dx;

    assign w_dy  = {r_y1[31], r_y1} - {r_y0[31], r_y0};
    assign w_dxx = {r_qx[31], r_qx} - {r_x0[31], r_x0};
    assign w_dx  = {r_x1[31], r_x1} - {r_x0[31], r_x0};

    // partial product: 17-bit halves of magnitude and offset
    logic [16:0] w_pa, w_pb;
    logic [33:0] w_pp;
    logic [65:0] w_pps;

    assign w_pa = r_cnt[0] ? {1'b0, r_mag[32:17]} : r_mag[16:0];
    assign w_pb = r_cnt[1] ? {1'b0, r_dxx[32:17]} : r_dxx[16:0];
    assign w_pp = {17'b0, w_pa} * {17'b0, w_pb};

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    w_pps = 66'(w_pp);
            2'd1:    w_pps = 66'(w_pp) << 17;
            2'd2:    w_pps = 66'(w_pp) << 17;
            default: w_pps = 66'(w_pp) << 34;
        endcase
    end

    // ---------------- dividers ----------------
    logic [63:0] w_snum;
    logic        w_start;
    logic        w_ibusy, w_sbusy;
    logic [32:0] w_iquo;
    logic [31:0] w_squo;
    logic        w_sat;
    logic [31:0] w_slope;

    assign w_snum  = 64'(r_mag) << tli_pkg::FRAC_BITS;
    assign w_start = (r_state == S_DSTART);
    assign w_sat   = {1'b0, w_snum[63:32]} >= r_dx;

    tli_div #(.QW(33), .DW(33)) u_idiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_rem   (r_prod[65:33]),
        .i_num   (r_prod[32:0]),
        .i_den   (r_dx),
        .o_busy  (w_ibusy),
        .o_quo   (w_iquo)
    );

    tli_div #(.QW(32), .DW(33)) u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_rem   ({1'b0, w_snum[63:32]}),
        .i_num   (w_snum[31:0]),
        .i_den   (r_dx),
        .o_busy  (w_sbusy),
        .o_quo   (w_squo)
    );

    always_comb begin
        if (!r_neg) begin
            w_slope = (w_sat || w_squo[31]) ? 32'h7FFF_FFFF : w_squo;
        end else begin
            w_slope = (w_sat || (w_squo > 32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - w_squo);
        end
    end

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= '0;
            r_col_count <= 4'd1;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == tli_pkg::CFG_ROW_COUNT) begin
                r_row_count <= i_cfg.data[8:0];
            end else if (i_cfg.index == tli_pkg::CFG_COL_COUNT) begin
                r_col_count <= i_cfg.data[3:0];
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // load a finished result, or drop the one just taken
            if (r_state == S_RESP && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_req.action == tli_pkg::ACT_QUERY) begin
                        r_xc    <= i_req.x_col;
                        r_yc    <= i_req.y_col;
                        r_qx    <= i_req.query_x;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_yv     <= '0;
                    r_sl     <= '0;
                    r_lo_out <= '0;
                    r_lo     <= '0;
                    r_hi     <= RW'(w_rows - 1'b1);
                    priority if (w_bad_col) begin
                        r_st    <= tli_pkg::ST_BAD_COL;
                        r_state <= S_RESP;
                    end else if (w_rows == '0) begin
                        r_st    <= tli_pkg::ST_EMPTY;
                        r_state <= S_RESP;
                    end else if (w_rows == CNT_W'(1)) begin
                        r_st    <= tli_pkg::ST_OK;
                        r_state <= S_ROW0;
                    end else begin
                        r_st    <= tli_pkg::ST_OK;
                        r_state <= S_PROBE;
                    end
                end
                S_ROW0:  r_state <= S_ROW0W;
                S_ROW0W: begin
                    r_yv    <= w_rdata;
                    r_state <= S_RESP;
                end
                S_PROBE: begin
                    if (w_more) begin
                        r_state <= S_CMP;
                    end else begin
                        r_lo_out <= 8'(r_lo);
                        r_cnt    <= '0;
                        r_state  <= S_FETCH;
                    end
                end
                S_CMP: begin
                    if ($signed(w_rdata) <= r_qx) begin
                        r_lo <= w_mid;
                    end else begin
                        r_hi <= w_mid;
                    end
                    r_state <= S_PROBE;
                end
                S_FETCH: begin
                    r_cnt <= r_cnt + 1'b1;
                    unique case (r_cnt)
                        3'd1:    r_x0 <= w_rdata;
                        3'd2:    r_x1 <= w_rdata;
                        3'd3:    r_y0 <= w_rdata;
                        3'd4: begin
                            r_y1    <= w_rdata;
                            r_state <= S_EVAL;
                        end
                        default: ;
                    endcase
                end
                S_EVAL: begin
                    r_mag  <= w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
                    r_neg  <= w_dy[32];
                    r_dxx  <= w_dxx;
                    r_dx   <= w_dx;
                    r_prod <= '0;
                    r_cnt  <= '0;
                    priority if (r_qx >= r_x1) begin
                        r_yv    <= r_y1;
                        r_state <= S_RESP;
                    end else if (r_qx <= r_x0) begin
                        r_yv    <= r_y0;
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= r_prod + w_pps;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 3'd3) begin
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (!w_ibusy && !w_sbusy) begin
                        r_yv    <= r_neg ? (r_y0 - $signed(w_iquo[31:0]))
                                         : (r_y0 + $signed(w_iquo[31:0]));
                        r_sl    <= w_slope;
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_res_yv    <= r_yv;
                        r_res_sl    <= r_sl;
                        r_res_lo    <= r_lo_out;
                        r_res_st    <= r_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign r_res_full = r_out_valid;

    assign o_rsp.valid        = r_res_full;
    assign o_rsp.y_value      = r_res_yv;
    assign o_rsp.slope        = r_res_sl;
    assign o_rsp.interval_low = r_res_lo;
    assign o_rsp.status       = r_res_st;

    // ---------------- assertions ----------------
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.action == tli_pkg::ACT_WRITE) |=> (r_state == S_IDLE))
        else $error("write request left the idle state");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_CMP) |-> (r_lo < r_hi))
        else $error("search bounds crossed");

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ibusy || w_sbusy) |-> (r_state == S_DWAIT))
        else $error("divider busy outside divide wait");

    a_resp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_valid && !o_rsp.ready) |=> (r_state == S_RESP))
        else $error("result dropped while output stalled");

    a_no_store_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE))
        else $error("cell store written during a query");

endmodule

// ===== tb/sv/table_linear_interpolator_test.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator_test
// Self-checking bench for the table linear interpolator. Cell writes and
// queries go through the request channel with random gaps and stalls. Each
// accepted write updates a local copy of the table, and each query's
// predicted y, slope, interval and status are checked in order against the
// response channel. The table size and column count change between phases.
// ----------------------------------------------------------------------------
module table_linear_interpolator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAB_ROWS = 256;
    localparam int TAB_COLS = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD = 600;
    localparam logic [tli_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct {
        tli_pkg::t_action   act;
        logic [7:0]         row;
        logic [2:0]         col;
        logic signed [31:0] val;
        logic [2:0]         xc;
        logic [2:0]         yc;
        logic signed [31:0] qx;
    } t_lookup_req;

    typedef struct {
        logic signed [31:0] y;
        logic signed [31:0] slope;
        logic [7:0]         lo;
        tli_pkg::t_status   st;
    } t_lookup_res;

    logic i_clk;
    logic i_rst_n;

    tli_cfg_if cfg_ch();
    tli_req_if req_ch();
    tli_rsp_if rsp_ch();

    table_linear_interpolator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // table copy and registers as the block sees them
    logic signed [31:0] cell_mem [TAB_ROWS*TAB_COLS];
    logic [8:0]         cur_rows;
    logic [3:0]         cur_cols;

    // stimulus side shadow of the table, used only to pick query values
    logic signed [31:0] gen_cells [TAB_ROWS*TAB_COLS];

    t_lookup_req request_q[$];
    t_lookup_res lookup_q[$];
    int          pushed_cnt = 0;
    int          accepted_cnt = 0;
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    bit          no_idle = 0;
    bit          long_hold_req = 0;
    bit          long_hold_done = 0;
    logic        req_fire;
    int          req_gap;
    int          rsp_hold;

    function automatic longint cell_of(int unsigned row, int unsigned col);
        return longint'(cell_mem[row*TAB_COLS + col]);
    endfunction

    function automatic t_lookup_res interpolate(t_lookup_req r);
        t_lookup_res  res;
        int unsigned  rows, cols, lo, hi, mid;
        longint       x, x0, x1, y0, y1, dy, dx, sl, mag;
        logic [127:0] prod, quo, a, b;
        res.y = 0;
        res.slope = 0;
        res.lo = 0;
        res.st = tli_pkg::ST_OK;
        rows = (cur_rows > TAB_ROWS) ? TAB_ROWS : cur_rows;
        cols = (cur_cols > TAB_COLS) ? TAB_COLS : cur_cols;
        x = longint'(r.qx);
        if (r.xc >= cols || r.yc >= cols) begin
            res.st = tli_pkg::ST_BAD_COL;
        end else if (rows == 0) begin
            res.st = tli_pkg::ST_EMPTY;
        end else if (rows == 1) begin
            res.y = cell_of(0, r.yc);
        end else begin
            lo = 0;
            hi = rows - 1;
            while (lo + 1 < hi) begin
                mid = (lo + hi) / 2;
                if (cell_of(mid, r.xc) <= x) lo = mid;
                else hi = mid;
            end
            x0 = cell_of(lo, r.xc);
            x1 = cell_of(lo + 1, r.xc);
            y0 = cell_of(lo, r.yc);
            y1 = cell_of(lo + 1, r.yc);
            dy = y1 - y0;
            res.lo = lo[7:0];
            // the upper end wins when both clamps hold
            if (x >= x1) begin
                res.y = y1;
            end else if (x <= x0) begin
                res.y = y0;
            end else begin
                dx = x1 - x0;
                mag = (dy < 0) ? -dy : dy;
                a = mag;
                b = x - x0;
                prod = a * b;
                quo = prod / 128'(dx);
                res.y = (dy < 0) ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]);
                sl = (dy * (64'sd1 <<< tli_pkg::FRAC_BITS)) / dx;
                if (sl > 64'sd2147483647) sl = 64'sd2147483647;
                if (sl < -64'sd2147483648) sl = -64'sd2147483648;
                res.slope = sl;
            end
        end
        return res;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // request driver: hold until accepted, then advance or idle
    always @(negedge i_clk) begin
        t_lookup_req it;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_gap <= 0;
        end else if (!req_ch.valid || req_fire) begin
            if (req_gap > 0) begin
                req_gap <= req_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                if (!no_idle && $urandom_range(0, 11) == 0) begin
                    req_gap <= $urandom_range(0, 13);
                    req_ch.valid <= 1'b0;
                end else begin
                    it = request_q.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.action     <= it.act;
                    req_ch.row_index  <= it.row;
                    req_ch.col_index  <= it.col;
                    req_ch.cell_value <= it.val;
                    req_ch.x_col      <= it.xc;
                    req_ch.y_col      <= it.yc;
                    req_ch.query_x    <= it.qx;
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold <= 0;
        end else if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_ch.ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            rsp_hold <= LONG_HOLD;
            long_hold_done <= 1'b1;
            rsp_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            rsp_hold <= $urandom_range(0, 13);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // monitor: check responses, then apply accepted requests and config writes
    always @(posedge i_clk) begin
        t_lookup_req it;
        t_lookup_res want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL table_linear_interpolator");
            $finish;
        end
        req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
        if (!i_rst_n) begin
            cur_rows <= 9'd0;
            cur_cols <= 4'd1;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (lookup_q.size() == 0) begin
                    $error("unexpected response y_value %0d", rsp_ch.y_value);
                    fail_cnt++;
                end else begin
                    want = lookup_q.pop_front();
                    if (rsp_ch.y_value !== want.y) begin
                        $error("y_value expected %0d got %0d", want.y, rsp_ch.y_value);
                        fail_cnt++;
                    end
                    if (rsp_ch.slope !== want.slope) begin
                        $error("slope expected %0d got %0d", want.slope, rsp_ch.slope);
                        fail_cnt++;
                    end
                    if (rsp_ch.interval_low !== want.lo) begin
                        $error("interval_low expected %0d got %0d", want.lo,
                               rsp_ch.interval_low);
                        fail_cnt++;
                    end
                    if (rsp_ch.status !== want.st) begin
                        $error("status expected %0d got %0d", want.st, rsp_ch.status);
                        fail_cnt++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                it.act = tli_pkg::t_action'(req_ch.action);
                it.row = req_ch.row_index;
                it.col = req_ch.col_index;
                it.val = req_ch.cell_value;
                it.xc  = req_ch.x_col;
                it.yc  = req_ch.y_col;
                it.qx  = req_ch.query_x;
                if (it.act == tli_pkg::ACT_WRITE) cell_mem[it.row*TAB_COLS + it.col] = it.val;
                else lookup_q.insert(lookup_q.size(), interpolate(it));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    tli_pkg::CFG_ROW_COUNT: cur_rows <= cfg_ch.data[8:0];
                    tli_pkg::CFG_COL_COUNT: cur_cols <= cfg_ch.data[3:0];
                    default: ;
                endcase
            end
        end
    end

    task automatic wait_drained();
        while (!(accepted_cnt == pushed_cnt && lookup_q.size() == 0)) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [tli_pkg::CFG_IDX_W-1:0] idx,
                             logic [tli_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic put_cell(int row, int col, logic signed [31:0] v);
        t_lookup_req it;
        it = '{tli_pkg::ACT_WRITE, row[7:0], col[2:0], v, 3'($urandom), 3'($urandom),
               $urandom};
        gen_cells[row*TAB_COLS + col] = v;
        request_q.insert(request_q.size(), it);
        pushed_cnt++;
    endtask

    task automatic put_query(int xc, int yc, logic signed [31:0] qx);
        t_lookup_req it;
        it = '{tli_pkg::ACT_QUERY, 8'($urandom), 3'($urandom), $urandom, xc[2:0], yc[2:0],
               qx};
        request_q.insert(request_q.size(), it);
        pushed_cnt++;
    endtask

    // fill used cells; most columns ascending so searches go deep
    task automatic fill_table(int rows, int cols);
        longint acc, step;
        bit     asc;
        for (int c = 0; c < cols; c++) begin
            asc = ($urandom_range(0, 3) != 0);
            acc = -longint'($urandom_range(0, 32'h7fff_ffff));
            for (int r = 0; r < rows; r++) begin
                case ($urandom_range(0, 7))
                    0: step = 0;
                    1, 2: step = $urandom_range(1, 65536);
                    default: step = $urandom_range(1, (rows > 32) ? 32'h7f_ffff : 32'h3fff_ffff);
                endcase
                acc = acc + step;
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                put_cell(r, c, asc ? acc[31:0] : $urandom);
            end
        end
    endtask

    task automatic run_phase(int rows_cfg, int cols_cfg, int n_items);
        int rows, cols, xc, yc, r;
        logic signed [31:0] qx;
        rows = (rows_cfg > TAB_ROWS) ? TAB_ROWS : rows_cfg;
        cols = (cols_cfg > TAB_COLS) ? TAB_COLS : cols_cfg;
        write_reg(tli_pkg::CFG_ROW_COUNT, 16'(rows_cfg));
        write_reg(tli_pkg::CFG_COL_COUNT, 16'(cols_cfg));
        fill_table(rows, cols);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0 && rows > 0 && cols > 0)
                    put_cell($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                             $urandom);
                else
                    put_cell($urandom_range(0, TAB_ROWS - 1), $urandom_range(0, TAB_COLS - 1),
                             $urandom);
            end else begin
                if (cols > 0 && $urandom_range(0, 6) != 0) begin
                    xc = $urandom_range(0, cols - 1);
                    yc = $urandom_range(0, cols - 1);
                end else begin
                    xc = $urandom_range(0, 7);
                    yc = $urandom_range(0, 7);
                end
                r = (rows > 0) ? $urandom_range(0, rows - 1) : 0;
                case ($urandom_range(0, 9))
                    0: qx = $urandom;
                    1: qx = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                    2: qx = gen_cells[r*TAB_COLS + xc] + $signed($urandom_range(0, 2)) - 1;
                    default: qx = gen_cells[r*TAB_COLS + xc]
                                  + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
                endcase
                put_query(xc, yc, qx);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = tli_pkg::CFG_ROW_COUNT;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.action = tli_pkg::ACT_WRITE;
        req_ch.row_index = '0;
        req_ch.col_index = '0;
        req_ch.cell_value = '0;
        req_ch.x_col = '0;
        req_ch.y_col = '0;
        req_ch.query_x = '0;
        rsp_ch.ready = 1'b0;
        req_fire = 1'b0;
        for (int i = 0; i < TAB_ROWS*TAB_COLS; i++) gen_cells[i] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table and bad columns straight after reset
        put_query(0, 0, 0);
        put_query(1, 0, 5);
        write_reg(tli_pkg::CFG_COL_COUNT, 16'd0);
        put_query(0, 0, 0);
        write_reg(CFG_IDX_SPARE, 16'hffff);
        // single row
        write_reg(tli_pkg::CFG_ROW_COUNT, 16'd1);
        write_reg(tli_pkg::CFG_COL_COUNT, 16'd2);
        put_cell(0, 0, 7);
        put_cell(0, 1, -5);
        put_query(0, 1, 32'sh8000_0000);
        put_query(1, 0, 32'sh7fff_ffff);
        // two rows: slope saturation both ways, clamps, reversed and flat x
        write_reg(tli_pkg::CFG_ROW_COUNT, 16'd2);
        put_cell(0, 0, 0);
        put_cell(1, 0, 2);
        put_cell(0, 1, 32'sh8000_0000);
        put_cell(1, 1, 32'sh7fff_ffff);
        put_query(0, 1, 1);
        put_query(0, 1, 0);
        put_query(0, 1, 2);
        put_query(0, 1, 32'sh8000_0000);
        put_query(0, 1, 32'sh7fff_ffff);
        put_cell(0, 1, 32'sh7fff_ffff);
        put_cell(1, 1, 32'sh8000_0000);
        put_query(0, 1, 1);
        put_cell(0, 0, 5);
        put_cell(1, 0, 3);
        put_query(0, 1, 4);
        put_cell(0, 0, 3);
        put_query(0, 1, 3);

        run_phase(2, 8, 80);
        run_phase(5, 3, 120);
        // hold responses off long enough to back up the request side
        @(posedge i_clk);
        long_hold_req = 1'b1;
        run_phase(17, 8, 150);
        run_phase(256, 2, 80);
        run_phase(511, 1, 60);
        wait_drained();
        no_idle = 1'b1;
        run_phase(3, 15, 80);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("PASS table_linear_interpolator");
        else
            $display("FAIL table_linear_interpolator");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/tli_pkg.sv
rtl/tli_ifs.sv
rtl/tli_mem.sv
rtl/tli_div.sv
rtl/table_linear_interpolator.sv
tb/sv/table_linear_interpolator_test.sv
